[rtl/aphc_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// aphc_pkg
// Shared types and constants for the address pair hit counter.
// ----------------------------------------------------------------------------
package aphc_pkg;

   localparam int unsigned ADDR_W  = 64;
   localparam int unsigned KEY_W   = 2 * ADDR_W;
   localparam int unsigned COUNT_W = 32;
   localparam int unsigned SLOT_W  = 8;
   localparam int unsigned RSP_W   = 48;

   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_RESULT
   } state_type;

   typedef struct packed {
      logic [SLOT_W-1:0]  slot_index;
      logic [COUNT_W-1:0] hit_count;
      logic               new_entry;
      logic               dropped;
   } result_type;

endpackage
`default_nettype wire

[rtl/aphc_table.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// aphc_table
// Key and count storage: one read port and one write port, registered reads.
// ----------------------------------------------------------------------------
module aphc_table #(
   parameter int unsigned TABLE_DEPTH = 256,
   parameter int unsigned IDX_W       = 8
) (
   input  wire                              clock,
   input  wire                              rd_en,
   input  wire  [IDX_W-1:0]                 rd_addr,
   output logic [aphc_pkg::KEY_W-1:0]       rd_key,
   output logic [aphc_pkg::COUNT_W-1:0]     rd_count,
   input  wire                              key_we,
   input  wire                              count_we,
   input  wire  [IDX_W-1:0]                 wr_addr,
   input  wire  [aphc_pkg::KEY_W-1:0]       wr_key,
   input  wire  [aphc_pkg::COUNT_W-1:0]     wr_count
);

   logic [aphc_pkg::KEY_W-1:0]   key_mem   [TABLE_DEPTH];
   logic [aphc_pkg::COUNT_W-1:0] count_mem [TABLE_DEPTH];

   logic [aphc_pkg::KEY_W-1:0]   rd_key_ff;
   logic [aphc_pkg::COUNT_W-1:0] rd_count_ff;

   always_ff @(posedge clock) begin
      if (key_we) begin
         key_mem[wr_addr] <= wr_key;
      end
      if (count_we) begin
         count_mem[wr_addr] <= wr_count;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_key_ff   <= key_mem[rd_addr];
         rd_count_ff <= count_mem[rd_addr];
      end
   end

   assign rd_key   = rd_key_ff;
   assign rd_count = rd_count_ff;

endmodule
`default_nettype wire

[rtl/aphc_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// aphc_ctrl
// Search sequencer: scans occupied slots one per cycle, then updates,
// inserts or drops (table full) and hands the result to the output stage.
// ----------------------------------------------------------------------------
module aphc_ctrl #(
   parameter int unsigned TABLE_DEPTH = 256,
   parameter int unsigned IDX_W       = 8,
   parameter int unsigned OCC_W       = 9
) (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              req_valid,
   input  wire  [aphc_pkg::KEY_W-1:0]       req_key,
   output logic                             req_ready,
   output logic                             rd_en,
   output logic [IDX_W-1:0]                 rd_addr,
   input  wire  [aphc_pkg::KEY_W-1:0]       rd_key,
   input  wire  [aphc_pkg::COUNT_W-1:0]     rd_count,
   output logic                             key_we,
   output logic                             count_we,
   output logic [IDX_W-1:0]                 wr_addr,
   output logic [aphc_pkg::KEY_W-1:0]       wr_key,
   output logic [aphc_pkg::COUNT_W-1:0]     wr_count,
   output logic                             res_valid,
   input  wire                              res_ready,
   output aphc_pkg::result_type             res
);

   aphc_pkg::state_type  state_ff, state_in;
   logic [OCC_W-1:0]     occ_ff, occ_in;
   logic [OCC_W-1:0]     ptr_ff, ptr_in;
   logic                 chk_valid_ff, chk_valid_in;
   logic [IDX_W-1:0]     chk_idx_ff, chk_idx_in;
   logic [aphc_pkg::KEY_W-1:0] key_ff, key_in;
   aphc_pkg::result_type res_ff, res_in;

   logic                       issue;
   logic                       hit;
   logic                       full;
   logic [aphc_pkg::COUNT_W-1:0] count_inc;

   assign issue     = (ptr_ff < occ_ff);
   assign hit       = chk_valid_ff && (rd_key == key_ff);
   assign full      = (occ_ff == OCC_W'(TABLE_DEPTH));
   assign count_inc = (rd_count == aphc_pkg::COUNT_MAX) ? rd_count
                                                        : rd_count + 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= aphc_pkg::ST_IDLE;
         occ_ff       <= '0;
         chk_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         occ_ff       <= occ_in;
         chk_valid_ff <= chk_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff     <= ptr_in;
      chk_idx_ff <= chk_idx_in;
      key_ff     <= key_in;
      res_ff     <= res_in;
   end

   always_comb begin
      state_in     = state_ff;
      occ_in       = occ_ff;
      ptr_in       = ptr_ff;
      chk_valid_in = 1'b0;
      chk_idx_in   = chk_idx_ff;
      key_in       = key_ff;
      res_in       = res_ff;
      req_ready    = 1'b0;
      res_valid    = 1'b0;
      rd_en        = 1'b0;
      rd_addr      = ptr_ff[IDX_W-1:0];
      key_we       = 1'b0;
      count_we     = 1'b0;
      wr_addr      = chk_idx_ff;
      wr_key       = key_ff;
      wr_count     = count_inc;

      case (state_ff)
         aphc_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               key_in   = req_key;
               ptr_in   = '0;
               state_in = aphc_pkg::ST_SEARCH;
            end
         end
         aphc_pkg::ST_SEARCH: begin
            if (hit) begin
               count_we          = 1'b1;
               res_in.slot_index = 8'(chk_idx_ff);
               res_in.hit_count  = count_inc;
               res_in.new_entry  = 1'b0;
               res_in.dropped    = 1'b0;
               state_in          = aphc_pkg::ST_RESULT;
            end else if (!issue) begin
               // all occupied slots checked without a match
               if (full) begin
                  res_in.slot_index = '0;
                  res_in.hit_count  = '0;
                  res_in.new_entry  = 1'b0;
                  res_in.dropped    = 1'b1;
               end else begin
                  key_we            = 1'b1;
                  count_we          = 1'b1;
                  wr_addr           = occ_ff[IDX_W-1:0];
                  wr_count          = aphc_pkg::COUNT_W'(1);
                  occ_in            = occ_ff + 1'b1;
                  res_in.slot_index = 8'(occ_ff);
                  res_in.hit_count  = aphc_pkg::COUNT_W'(1);
                  res_in.new_entry  = 1'b1;
                  res_in.dropped    = 1'b0;
               end
               state_in = aphc_pkg::ST_RESULT;
            end else begin
               rd_en        = 1'b1;
               ptr_in       = ptr_ff + 1'b1;
               chk_valid_in = 1'b1;
               chk_idx_in   = ptr_ff[IDX_W-1:0];
            end
         end
         aphc_pkg::ST_RESULT: begin
            res_valid = 1'b1;
            if (res_ready) begin
               state_in = aphc_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = aphc_pkg::ST_IDLE;
         end
      endcase
   end

   assign res = res_ff;

endmodule
`default_nettype wire

[rtl/address_pair_hit_counter.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// address_pair_hit_counter
// Counts hits per distinct (instruction address, caller address) pair.
// ----------------------------------------------------------------------------
// Usage:
//  - req_ channel carries one sample per transaction: the instruction
//    address and the caller address.
//  - rsp_ channel returns exactly one result per sample: slot, count after
//    update, new-entry flag and dropped flag (table full, pair absent).
//  - The table sits in synchronous memories scanned one slot per cycle,
//    lowest slot first. A hit ends the scan at its slot; a miss checks
//    every occupied slot before it inserts or drops the sample. The scan
//    rate is bounded by the single memory read port.
//  - One sample is in work at a time; the next is accepted once the
//    previous result has moved into the output register, even while that
//    result still waits on rsp_tready.
//  - Reset empties the table (occupancy to zero); stored keys and counts
//    are not cleared and are never read before written.
//  - A stalled receiver holds the result in the output register and, once
//    the sequencer also holds a finished result, stops new samples.
// ----------------------------------------------------------------------------
module address_pair_hit_counter #(
   parameter int unsigned TABLE_DEPTH = 256
) (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          req_tvalid,
   output logic                         req_tready,
   input  wire  [127:0]                 req_tdata,   // [63:0] sample_address,
                                                     // [127:64] caller_address
   output logic                         rsp_tvalid,
   input  wire                          rsp_tready,
   output logic [aphc_pkg::RSP_W-1:0]   rsp_tdata    // [7:0] slot_index, [39:8] hit_count,
                                                     // [40] new_entry, [41] dropped,
                                                     // [47:42] zero
);

   localparam int unsigned IDX_W = $clog2(TABLE_DEPTH);
   localparam int unsigned OCC_W = $clog2(TABLE_DEPTH + 1);

   logic                             rd_en;
   logic [IDX_W-1:0]                 rd_addr;
   logic [aphc_pkg::KEY_W-1:0]       rd_key;
   logic [aphc_pkg::COUNT_W-1:0]     rd_count;
   logic                             key_we;
   logic                             count_we;
   logic [IDX_W-1:0]                 wr_addr;
   logic [aphc_pkg::KEY_W-1:0]       wr_key;
   logic [aphc_pkg::COUNT_W-1:0]     wr_count;
   logic                             res_valid;
   logic                             res_ready;
   aphc_pkg::result_type             res;

   logic                             rsp_valid_ff, rsp_valid_in;
   aphc_pkg::result_type             rsp_data_ff, rsp_data_in;

   aphc_ctrl #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .IDX_W       (IDX_W),
      .OCC_W       (OCC_W)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_key   (req_tdata),
      .req_ready (req_tready),
      .rd_en     (rd_en),
      .rd_addr   (rd_addr),
      .rd_key    (rd_key),
      .rd_count  (rd_count),
      .key_we    (key_we),
      .count_we  (count_we),
      .wr_addr   (wr_addr),
      .wr_key    (wr_key),
      .wr_count  (wr_count),
      .res_valid (res_valid),
      .res_ready (res_ready),
      .res       (res)
   );

   aphc_table #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .IDX_W       (IDX_W)
   ) u_table (
      .clock    (clock),
      .rd_en    (rd_en),
      .rd_addr  (rd_addr),
      .rd_key   (rd_key),
      .rd_count (rd_count),
      .key_we   (key_we),
      .count_we (count_we),
      .wr_addr  (wr_addr),
      .wr_key   (wr_key),
      .wr_count (wr_count)
   );

   // output register: free when empty or being drained this cycle
   assign res_ready = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (res_ready) begin
         rsp_valid_in = res_valid;
         if (res_valid) begin
            rsp_data_in = res;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'b0, rsp_data_ff.dropped, rsp_data_ff.new_entry,
                        rsp_data_ff.hit_count, rsp_data_ff.slot_index};

`ifndef SYNTHESIS
   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_data_ff.new_entry && rsp_data_ff.dropped))
      else $error("new_entry and dropped both set");

   a_new_count_one: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_data_ff.new_entry) |-> (rsp_data_ff.hit_count == 32'd1))
      else $error("new entry without count one");

   a_drop_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_data_ff.dropped) |->
         (rsp_data_ff.hit_count == 32'd0 && rsp_data_ff.slot_index == 8'd0))
      else $error("dropped result carries data");

   a_kept_nonzero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_data_ff.dropped) |-> (rsp_data_ff.hit_count != 32'd0))
      else $error("stored pair reports zero count");

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (key_we || count_we) |-> !req_tready)
      else $error("table written while accepting a sample");
`endif

endmodule
`default_nettype wire
